// ===== hdl/steering_particle_step_core_macros.svh =====
// Assertion macros for the steering particle core
`ifndef STEERING_PARTICLE_STEP_CORE_MACROS_SVH
`define STEERING_PARTICLE_STEP_CORE_MACROS_SVH

// Check that ante implies cons in the same cycle
`define SPST_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("spst assertion failed");

// Check that ante implies cons in the next cycle
`define SPST_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("spst assertion failed");

`endif

// ===== hdl/spst_pkg.sv =====
// Types, codes and constants of the steering particle core
`default_nettype none
package spst_pkg;

  localparam int FIELD_W        = 24;
  localparam int CFG_W          = 23;
  localparam int WEIGHT_W       = 17;
  localparam int COORD_BITS_DEF = 24;
  localparam int ALU_W_DEF      = 27;

  localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = 17'd65536;

  localparam logic [22:0] CLOSE_ENOUGH_RST  = 23'd163840;
  localparam logic [22:0] MAX_SPEED_RST     = 23'd16384;
  localparam logic [22:0] MAX_FORCE_RST     = 23'd410;
  localparam logic [22:0] KILL_DISTANCE_RST = 23'd24576;
  localparam logic [22:0] UP_BIAS_RST       = 23'd410;
  localparam logic [15:0] WIND_DECAY_RST    = 16'd58327;
  localparam logic [16:0] BLEND_RATE_RST    = 17'd1638;

  typedef enum logic [2:0] {
    CFG_CLOSE_ENOUGH  = 3'd0,
    CFG_MAX_SPEED     = 3'd1,
    CFG_MAX_FORCE     = 3'd2,
    CFG_KILL_DISTANCE = 3'd3,
    CFG_UP_BIAS       = 3'd4,
    CFG_WIND_DECAY    = 3'd5,
    CFG_BLEND_RATE    = 3'd6
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ACT_STEP = 2'd0,
    ACT_LOAD = 2'd1,
    ACT_WIND = 2'd2
  } action_e;

  typedef enum logic [1:0] {
    ALU_MUL  = 2'd0,
    ALU_DIV  = 2'd1,
    ALU_SQRT = 2'd2
  } alu_op_e;

  typedef enum logic [4:0] {
    S_IDLE, S_SQ_DX, S_SQ_DY, S_DIST, S_SPD_MUL, S_SPD_DIV,
    S_DX_MUL, S_DX_DIV, S_DY_MUL, S_DY_DIV, S_STEER,
    S_SX_SQ, S_SY_SQ, S_MAG, S_FX_MUL, S_FX_DIV, S_FY_MUL, S_FY_DIV,
    S_WIND, S_POS, S_OUT
  } state_e;

  typedef struct packed {
    logic    start;
    alu_op_e op;
  } alu_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } alu_stat_t;

  typedef struct packed {
    logic [1:0]                 action;
    logic signed [FIELD_W-1:0]  target_x;
    logic signed [FIELD_W-1:0]  target_y;
    logic signed [FIELD_W-1:0]  init_pos_x;
    logic signed [FIELD_W-1:0]  init_pos_y;
    logic signed [FIELD_W-1:0]  init_vel_x;
    logic signed [FIELD_W-1:0]  init_vel_y;
    logic signed [FIELD_W-1:0]  wind_value;
  } in_beat_t;

  typedef struct packed {
    logic signed [FIELD_W-1:0]  out_pos_x;
    logic signed [FIELD_W-1:0]  out_pos_y;
    logic signed [FIELD_W-1:0]  out_vel_x;
    logic signed [FIELD_W-1:0]  out_vel_y;
    logic                       is_killed;
    logic [WEIGHT_W-1:0]        blend_weight;
  } out_beat_t;

endpackage
`default_nettype wire

// ===== hdl/spst_alu.sv =====
// Bit-serial multiply, divide and square root unit
`default_nettype none
module spst_alu #(
  parameter int W = spst_pkg::ALU_W_DEF
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire spst_pkg::alu_ctrl_t ctrl_i,
  input  wire logic [W-1:0]        a_i,
  input  wire logic [2*W-1:0]      x_i,
  output spst_pkg::alu_stat_t      stat_o,
  output logic [2*W-1:0]           res_o
);

  localparam int PW = 2 * W;
  localparam int CNTW = $clog2(W);

  logic                busy_q, busy_d, done_q, done_d;
  logic [CNTW-1:0]     cnt_q, cnt_d;
  spst_pkg::alu_op_e   op_q, op_d;
  logic [W-1:0]        a_q, a_d;
  logic [PW-1:0]       r_q, r_d;
  logic [W:0]          rem_q, rem_d;
  logic [W-1:0]        root_q, root_d;

  logic [W:0]   msum, dt, dtt;
  logic         dge, sge;
  logic [W+2:0] st, trial, sdiff;

  always_comb begin
    // multiply: add multiplicand on the low bit, shift right
    msum  = {1'b0, r_q[PW-1:W]} + (r_q[0] ? {1'b0, a_q} : '0);
    // divide: restoring, one quotient bit a cycle
    dt    = {r_q[PW-1:W], r_q[W-1]};
    dge   = dt >= {1'b0, a_q};
    dtt   = dge ? dt - {1'b0, a_q} : dt;
    // square root: two radicand bits a cycle
    st    = {rem_q, r_q[PW-1:PW-2]};
    trial = {1'b0, root_q, 2'b01};
    sge   = st >= trial;
    sdiff = sge ? st - trial : st;

    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    op_d   = op_q;
    a_d    = a_q;
    r_d    = r_q;
    rem_d  = rem_q;
    root_d = root_q;
    if (ctrl_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      op_d   = ctrl_i.op;
      a_d    = a_i;
      r_d    = x_i;
      rem_d  = '0;
      root_d = '0;
    end else if (busy_q) begin
      unique case (op_q)
        spst_pkg::ALU_MUL: r_d = {msum, r_q[W-1:1]};
        spst_pkg::ALU_DIV: r_d = {dtt[W-1:0], r_q[W-2:0], dge};
        spst_pkg::ALU_SQRT: begin
          rem_d  = sdiff[W:0];
          root_d = {root_q[W-2:0], sge};
          r_d    = {r_q[PW-3:0], 2'b00};
          if (cnt_q == CNTW'(W - 1)) begin
            r_d = PW'(root_d);
          end
        end
        default: r_d = r_q;
      endcase
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CNTW'(W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      op_q   <= spst_pkg::ALU_MUL;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
      op_q   <= op_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q    <= a_d;
    r_q    <= r_d;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign res_o       = r_q;

endmodule
`default_nettype wire

// ===== hdl/steering_particle_step_core.sv =====
// Top level of the steering particle core: sequencer, state and channels
//
// Use: one particle with arrive steering toward a target, Q12.12 values.
// Input channel (in_valid_i / in_stall_o, beat in_beat_i): one action a beat,
// step, load position and velocity, or set wind. Output channel
// (out_valid_o / out_stall_i, beat out_beat_o): one beat per input beat,
// the particle state after that action. Config channel (cfg_valid_i /
// cfg_ready_o): always ready; write only while the core is idle.
// A load, a set wind or an unused code goes from S_IDLE to S_OUT, which loads
// the output register once the slot is free and returns to S_IDLE for the next
// beat. A step runs up to 17 bit-serial operations on the shared unit of width
// W = max(COORD_BITS,24)+3 (27 at the default), plus the steer, position and
// output states, fewer when the particle sits on the target. One item is in
// work at a time. The output register holds a finished beat while the
// receiver stalls; the next item is taken meanwhile and waits at the end of
// its sequence.
// Reset: position, velocity, wind, kill flag and colour weight clear;
// config registers return to their defaults.
`default_nettype none
`include "steering_particle_step_core_macros.svh"
module steering_particle_step_core #(
  parameter int COORD_BITS = spst_pkg::COORD_BITS_DEF
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   in_valid_i,
  output logic                        in_stall_o,
  input  wire spst_pkg::in_beat_t     in_beat_i,
  output logic                        out_valid_o,
  input  wire logic                   out_stall_i,
  output spst_pkg::out_beat_t         out_beat_o,
  input  wire logic                   cfg_valid_i,
  output logic                        cfg_ready_o,
  input  wire logic [2:0]             cfg_index_i,
  input  wire logic [spst_pkg::CFG_W-1:0] cfg_data_i
);

  localparam int CW = COORD_BITS;
  localparam int MX = (CW > spst_pkg::FIELD_W) ? CW : spst_pkg::FIELD_W;
  localparam int AW = MX + 3;
  localparam int PW = 2 * AW;
  localparam logic signed [AW-1:0] SAT_HI = {{(AW-CW+1){1'b0}}, {(CW-1){1'b1}}};
  localparam logic signed [AW-1:0] SAT_LO = {{(AW-CW+1){1'b1}}, {(CW-1){1'b0}}};

  function automatic logic [AW-1:0] mag(input logic signed [AW-1:0] v);
    return v[AW-1] ? AW'(-v) : AW'(v);
  endfunction

  function automatic logic signed [AW-1:0] sgn(input logic neg, input logic [AW-1:0] q);
    return neg ? -$signed(q) : $signed(q);
  endfunction

  function automatic logic signed [CW-1:0] sat(input logic signed [AW-1:0] v);
    if (v > SAT_HI) return SAT_HI[CW-1:0];
    if (v < SAT_LO) return SAT_LO[CW-1:0];
    return v[CW-1:0];
  endfunction

  // config registers
  logic [22:0] ce_q, ms_q, mf_q, kd_q, ub_q;
  logic [15:0] wd_q;
  logic [16:0] br_q;

  // particle state
  logic signed [CW-1:0] px_q, py_q, vx_q, vy_q, wind_q;
  logic                 killed_q;
  logic [16:0]          cw_q;

  // step working registers
  logic signed [spst_pkg::FIELD_W-1:0] tx_q, ty_q;
  logic signed [AW-1:0] dx_q, dy_q, desx_q, desy_q, sx_q, sy_q;
  logic [AW-1:0]        dist_q, speed_q, m_q;
  logic [PW-1:0]        sumsq_q;

  spst_pkg::state_e    state_q, state_d;
  logic                go_q, go_d;
  spst_pkg::alu_ctrl_t alu_ctrl;
  spst_pkg::alu_stat_t alu_stat;
  logic [AW-1:0]       alu_a;
  logic [PW-1:0]       alu_x, alu_res;

  spst_pkg::out_beat_t out_q;
  logic                out_valid_q;

  logic in_acc, out_free, out_load;
  logic signed [AW-1:0] hx_sum, hx;
  logic [17:0]          cw_sum;

  assign in_stall_o  = (state_q != spst_pkg::S_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_load    = (state_q == spst_pkg::S_OUT) && out_free;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_beat_o  = out_q;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      spst_pkg::S_IDLE: begin
        if (in_acc) begin
          state_d = (in_beat_i.action == spst_pkg::ACT_STEP) ? spst_pkg::S_SQ_DX
                                                            : spst_pkg::S_OUT;
        end
      end
      spst_pkg::S_SQ_DX:   if (alu_stat.done) state_d = spst_pkg::S_SQ_DY;
      spst_pkg::S_SQ_DY:   if (alu_stat.done) state_d = spst_pkg::S_DIST;
      spst_pkg::S_DIST: begin
        if (alu_stat.done) begin
          if (alu_res[AW-1:0] < AW'(ce_q))   state_d = spst_pkg::S_SPD_MUL;
          else if (alu_res[AW-1:0] == '0)    state_d = spst_pkg::S_STEER;
          else                               state_d = spst_pkg::S_DX_MUL;
        end
      end
      spst_pkg::S_SPD_MUL: if (alu_stat.done) state_d = spst_pkg::S_SPD_DIV;
      spst_pkg::S_SPD_DIV: begin
        if (alu_stat.done) begin
          state_d = (dist_q == '0) ? spst_pkg::S_STEER : spst_pkg::S_DX_MUL;
        end
      end
      spst_pkg::S_DX_MUL:  if (alu_stat.done) state_d = spst_pkg::S_DX_DIV;
      spst_pkg::S_DX_DIV:  if (alu_stat.done) state_d = spst_pkg::S_DY_MUL;
      spst_pkg::S_DY_MUL:  if (alu_stat.done) state_d = spst_pkg::S_DY_DIV;
      spst_pkg::S_DY_DIV:  if (alu_stat.done) state_d = spst_pkg::S_STEER;
      spst_pkg::S_STEER:   state_d = spst_pkg::S_SX_SQ;
      spst_pkg::S_SX_SQ:   if (alu_stat.done) state_d = spst_pkg::S_SY_SQ;
      spst_pkg::S_SY_SQ:   if (alu_stat.done) state_d = spst_pkg::S_MAG;
      spst_pkg::S_MAG: begin
        if (alu_stat.done) begin
          state_d = (alu_res[AW-1:0] == '0) ? spst_pkg::S_WIND : spst_pkg::S_FX_MUL;
        end
      end
      spst_pkg::S_FX_MUL:  if (alu_stat.done) state_d = spst_pkg::S_FX_DIV;
      spst_pkg::S_FX_DIV:  if (alu_stat.done) state_d = spst_pkg::S_FY_MUL;
      spst_pkg::S_FY_MUL:  if (alu_stat.done) state_d = spst_pkg::S_FY_DIV;
      spst_pkg::S_FY_DIV:  if (alu_stat.done) state_d = spst_pkg::S_WIND;
      spst_pkg::S_WIND:    if (alu_stat.done) state_d = spst_pkg::S_POS;
      spst_pkg::S_POS:     state_d = spst_pkg::S_OUT;
      spst_pkg::S_OUT:     if (out_free) state_d = spst_pkg::S_IDLE;
      default:             state_d = spst_pkg::S_IDLE;
    endcase
    // launch the serial unit on entry to each of its states
    go_d = (state_d != state_q) && (state_d != spst_pkg::S_IDLE) &&
           (state_d != spst_pkg::S_STEER) && (state_d != spst_pkg::S_POS) &&
           (state_d != spst_pkg::S_OUT);
  end

  // serial unit operands
  always_comb begin
    alu_ctrl.start = go_q;
    alu_ctrl.op    = spst_pkg::ALU_MUL;
    alu_a          = '0;
    alu_x          = '0;
    unique case (state_q)
      spst_pkg::S_SQ_DX: begin
        alu_a = mag(dx_q);
        alu_x = PW'(mag(dx_q));
      end
      spst_pkg::S_SQ_DY: begin
        alu_a = mag(dy_q);
        alu_x = PW'(mag(dy_q));
      end
      spst_pkg::S_DIST: begin
        alu_ctrl.op = spst_pkg::ALU_SQRT;
        alu_x       = sumsq_q;
      end
      spst_pkg::S_SPD_MUL: begin
        alu_a = dist_q;
        alu_x = PW'(ms_q);
      end
      spst_pkg::S_SPD_DIV: begin
        alu_ctrl.op = spst_pkg::ALU_DIV;
        alu_a       = AW'(ce_q);
        alu_x       = alu_res;
      end
      spst_pkg::S_DX_MUL: begin
        alu_a = mag(dx_q);
        alu_x = PW'(speed_q);
      end
      spst_pkg::S_DY_MUL: begin
        alu_a = mag(dy_q);
        alu_x = PW'(speed_q);
      end
      spst_pkg::S_DX_DIV, spst_pkg::S_DY_DIV: begin
        alu_ctrl.op = spst_pkg::ALU_DIV;
        alu_a       = dist_q;
        alu_x       = alu_res;
      end
      spst_pkg::S_SX_SQ: begin
        alu_a = mag(sx_q);
        alu_x = PW'(mag(sx_q));
      end
      spst_pkg::S_SY_SQ: begin
        alu_a = mag(sy_q);
        alu_x = PW'(mag(sy_q));
      end
      spst_pkg::S_MAG: begin
        alu_ctrl.op = spst_pkg::ALU_SQRT;
        alu_x       = sumsq_q;
      end
      spst_pkg::S_FX_MUL: begin
        alu_a = mag(sx_q);
        alu_x = PW'(mf_q);
      end
      spst_pkg::S_FY_MUL: begin
        alu_a = mag(sy_q);
        alu_x = PW'(mf_q);
      end
      spst_pkg::S_FX_DIV, spst_pkg::S_FY_DIV: begin
        alu_ctrl.op = spst_pkg::ALU_DIV;
        alu_a       = m_q;
        alu_x       = alu_res;
      end
      spst_pkg::S_WIND: begin
        alu_a = mag(AW'(wind_q));
        alu_x = PW'(wd_q);
      end
      default: alu_a = '0;
    endcase
  end

  spst_alu #(.W(AW)) u_alu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (alu_ctrl),
    .a_i    (alu_a),
    .x_i    (alu_x),
    .stat_o (alu_stat),
    .res_o  (alu_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= spst_pkg::S_IDLE;
      go_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      go_q    <= go_d;
    end
  end

  // config writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ce_q <= spst_pkg::CLOSE_ENOUGH_RST;
      ms_q <= spst_pkg::MAX_SPEED_RST;
      mf_q <= spst_pkg::MAX_FORCE_RST;
      kd_q <= spst_pkg::KILL_DISTANCE_RST;
      ub_q <= spst_pkg::UP_BIAS_RST;
      wd_q <= spst_pkg::WIND_DECAY_RST;
      br_q <= spst_pkg::BLEND_RATE_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        spst_pkg::CFG_CLOSE_ENOUGH:  ce_q <= cfg_data_i;
        spst_pkg::CFG_MAX_SPEED:     ms_q <= cfg_data_i;
        spst_pkg::CFG_MAX_FORCE:     mf_q <= cfg_data_i;
        spst_pkg::CFG_KILL_DISTANCE: kd_q <= cfg_data_i;
        spst_pkg::CFG_UP_BIAS:       ub_q <= cfg_data_i;
        spst_pkg::CFG_WIND_DECAY:    wd_q <= cfg_data_i[15:0];
        spst_pkg::CFG_BLEND_RATE:    br_q <= cfg_data_i[16:0];
        default:                     ce_q <= ce_q;
      endcase
    end
  end

  // halve desired x toward zero
  always_comb begin
    hx_sum = desx_q + $signed({{(AW-1){1'b0}}, desx_q[AW-1]});
    hx     = hx_sum >>> 1;
    cw_sum = 18'(cw_q) + 18'(br_q);
  end

  // particle state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      px_q     <= '0;
      py_q     <= '0;
      vx_q     <= '0;
      vy_q     <= '0;
      wind_q   <= '0;
      killed_q <= 1'b0;
      cw_q     <= '0;
    end else begin
      if (in_acc) begin
        case (in_beat_i.action)
          spst_pkg::ACT_LOAD: begin
            px_q <= sat(AW'(in_beat_i.init_pos_x));
            py_q <= sat(AW'(in_beat_i.init_pos_y));
            vx_q <= sat(AW'(in_beat_i.init_vel_x));
            vy_q <= sat(AW'(in_beat_i.init_vel_y));
          end
          spst_pkg::ACT_WIND: wind_q <= sat(AW'(in_beat_i.wind_value));
          default: wind_q <= wind_q;
        endcase
      end
      if (alu_stat.done && state_q == spst_pkg::S_FX_DIV) begin
        vx_q <= sat(AW'(vx_q) + sgn(sx_q[AW-1], alu_res[AW-1:0]));
      end
      if (alu_stat.done && state_q == spst_pkg::S_FY_DIV) begin
        vy_q <= sat(AW'(vy_q) + sgn(sy_q[AW-1], alu_res[AW-1:0]));
      end
      if (alu_stat.done && state_q == spst_pkg::S_WIND) begin
        wind_q <= sat(sgn(wind_q[CW-1], AW'(alu_res[PW-1:16])));
      end
      if (state_q == spst_pkg::S_POS) begin
        // snap inside the kill radius, else move by the new velocity
        if (dist_q <= AW'(kd_q)) begin
          px_q     <= sat(AW'(tx_q));
          py_q     <= sat(AW'(ty_q));
          killed_q <= 1'b1;
        end else begin
          px_q <= sat(AW'(px_q) + AW'(vx_q));
          py_q <= sat(AW'(py_q) + AW'(vy_q));
        end
        cw_q <= (cw_sum > 18'(spst_pkg::WEIGHT_ONE)) ? spst_pkg::WEIGHT_ONE : cw_sum[16:0];
      end
    end
  end

  // step working registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      tx_q   <= in_beat_i.target_x;
      ty_q   <= in_beat_i.target_y;
      dx_q   <= AW'(in_beat_i.target_x) - AW'(px_q);
      dy_q   <= AW'(in_beat_i.target_y) - AW'(py_q);
      desx_q <= '0;
      desy_q <= '0;
    end
    if (state_q == spst_pkg::S_STEER) begin
      sx_q <= hx + AW'(wind_q) - AW'(vx_q);
      sy_q <= desy_q - $signed(AW'(ub_q)) - AW'(vy_q);
    end
    if (alu_stat.done) begin
      case (state_q)
        spst_pkg::S_SQ_DX, spst_pkg::S_SX_SQ: sumsq_q <= alu_res;
        spst_pkg::S_SQ_DY, spst_pkg::S_SY_SQ: sumsq_q <= sumsq_q + alu_res;
        spst_pkg::S_DIST: begin
          dist_q  <= alu_res[AW-1:0];
          speed_q <= AW'(ms_q);
        end
        spst_pkg::S_SPD_DIV: speed_q <= alu_res[AW-1:0];
        spst_pkg::S_DX_DIV:  desx_q  <= sgn(dx_q[AW-1], alu_res[AW-1:0]);
        spst_pkg::S_DY_DIV:  desy_q  <= sgn(dy_q[AW-1], alu_res[AW-1:0]);
        spst_pkg::S_MAG:     m_q     <= alu_res[AW-1:0];
        default:             m_q     <= m_q;
      endcase
    end
  end

  // output register: load when the slot is free, drop on a taken beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q.out_pos_x    <= spst_pkg::FIELD_W'(px_q);
      out_q.out_pos_y    <= spst_pkg::FIELD_W'(py_q);
      out_q.out_vel_x    <= spst_pkg::FIELD_W'(vx_q);
      out_q.out_vel_y    <= spst_pkg::FIELD_W'(vy_q);
      out_q.is_killed    <= killed_q;
      out_q.blend_weight <= cw_q;
    end
  end

  `SPST_ASSERT_IMP(a_start_idle_unit, alu_ctrl.start, !alu_stat.busy)
  `SPST_ASSERT_IMP(a_done_in_seq, alu_stat.done, state_q != spst_pkg::S_IDLE)
  `SPST_ASSERT_NXT(a_out_hold, (state_q == spst_pkg::S_OUT) && out_valid_o && out_stall_i, state_q == spst_pkg::S_OUT)

endmodule
`default_nettype wire
